/* rtl/hsb_pkg.sv */
// Shared types, constants and defaults for the bucketed hash set.
package hsb_pkg;

    // Request and result field widths
    localparam int KEY_W = 31;
    localparam int OP_W  = 2;

    // Default geometry of the store
    localparam int NUM_BUCKETS_DEF      = 10;
    localparam int SLOTS_PER_BUCKET_DEF = 4;

    // Operation codes; the unused code behaves as a membership test
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_TEST   = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic was_member;
        logic bucket_full;
    } t_rsp;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic mul;
        logic rem;
        logic read;
        logic update;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clear_last;
    } t_sts;

endpackage

/* rtl/hsb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module hsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/hsb_datapath.sv */
// Datapath: key modulo by reciprocal multiply, bucket row RAM, slot compare and update.
module hsb_datapath #(
    parameter int NUM_BUCKETS      = hsb_pkg::NUM_BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = hsb_pkg::SLOTS_PER_BUCKET_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hsb_pkg::t_cmd i_cmd,
    input  hsb_pkg::t_req i_in_req,
    output hsb_pkg::t_sts o_sts,
    output hsb_pkg::t_rsp o_out_rsp
);

    import hsb_pkg::*;

    localparam int KW    = KEY_W;
    localparam int SLOTS = SLOTS_PER_BUCKET;
    localparam int SW    = KW + 1;
    localparam int ROW_W = SLOTS * SW;
    localparam int BKW   = $clog2(NUM_BUCKETS);
    localparam int RW    = $clog2(2 * NUM_BUCKETS);
    // floor(2^KW / N): estimated quotient is exact or one low
    localparam logic [2*KW-1:0] MULT_FULL = ((2*KW)'(1) << KW) / (2*KW)'(NUM_BUCKETS);
    localparam logic [KW-1:0]   MULT      = MULT_FULL[KW-1:0];

    logic [OP_W-1:0]  r_op;
    logic [KW-1:0]    r_key;
    logic [KW-1:0]    r_q;
    logic [RW-1:0]    r_rem;
    logic [BKW-1:0]   r_bucket;
    logic [BKW-1:0]   r_clr_cnt;
    t_rsp             r_rsp;

    logic [2*KW-1:0]  w_prod;
    logic [KW-1:0]    w_qn;
    logic [KW-1:0]    w_rem_full;
    logic [BKW-1:0]   w_bucket;

    logic             w_we;
    logic [BKW-1:0]   w_waddr;
    logic [ROW_W-1:0] w_wdata;
    logic [ROW_W-1:0] w_rdata;
    logic [ROW_W-1:0] w_new_row;

    logic [KW-1:0]    w_slot_key [SLOTS];
    logic [SLOTS-1:0] w_slot_vld;
    logic [SLOTS-1:0] w_hit;
    logic [SLOTS-1:0] w_free;
    logic [SLOTS-1:0] w_hit_oh;
    logic [SLOTS-1:0] w_free_oh;
    logic             w_hit_any;
    logic             w_ins;
    logic             w_del;
    logic             w_full;

    // Quotient estimate and remainder estimate in [0, 2N)
    assign w_prod     = (2*KW)'(r_key) * (2*KW)'(MULT);
    assign w_qn       = r_q * KW'(NUM_BUCKETS);
    assign w_rem_full = r_key - w_qn;

    // Correct the remainder with one compare and subtract
    always_comb begin
        if (r_rem >= RW'(NUM_BUCKETS)) begin
            w_bucket = BKW'(r_rem - RW'(NUM_BUCKETS));
        end else begin
            w_bucket = BKW'(r_rem);
        end
    end

    // Capture request and step through the modulo stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in_req.operation;
            r_key <= i_in_req.key;
        end
        if (i_cmd.mul) begin
            r_q <= w_prod[2*KW-1:KW];
        end
        if (i_cmd.rem) begin
            r_rem <= w_rem_full[RW-1:0];
        end
        if (i_cmd.read) begin
            r_bucket <= w_bucket;
        end
    end

    // Sweep the rows to empty after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear && r_clr_cnt != BKW'(NUM_BUCKETS - 1)) begin
            r_clr_cnt <= r_clr_cnt + BKW'(1);
        end
    end

    assign o_sts.clear_last = (r_clr_cnt == BKW'(NUM_BUCKETS - 1));

    // Split the row into slots and compare all of them at once
    always_comb begin
        for (int s = 0; s < SLOTS; s++) begin
            w_slot_key[s] = w_rdata[s*SW +: KW];
            w_slot_vld[s] = w_rdata[s*SW + KW];
            w_hit[s]      = w_slot_vld[s] && (w_slot_key[s] == r_key);
            w_free[s]     = !w_slot_vld[s];
        end
    end

    // Pick the lowest hit and the lowest free slot
    assign w_hit_oh  = w_hit & (~w_hit + SLOTS'(1));
    assign w_free_oh = w_free & (~w_free + SLOTS'(1));
    assign w_hit_any = |w_hit;
    assign w_ins     = (r_op == OP_INSERT) && !w_hit_any;
    assign w_del     = (r_op == OP_DELETE) && w_hit_any;
    assign w_full    = w_ins && !(|w_free);

    // Build the updated row
    always_comb begin
        w_new_row = w_rdata;
        for (int s = 0; s < SLOTS; s++) begin
            if (w_ins && w_free_oh[s]) begin
                w_new_row[s*SW +: SW] = {1'b1, r_key};
            end else if (w_del && w_hit_oh[s]) begin
                w_new_row[s*SW + KW] = 1'b0;
            end
        end
    end

    // Select between clearing sweep and row write-back
    always_comb begin
        w_we    = i_cmd.clear || i_cmd.update;
        w_waddr = i_cmd.clear ? r_clr_cnt : r_bucket;
        w_wdata = i_cmd.clear ? '0 : w_new_row;
    end

    hsb_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_BUCKETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_bucket),
        .o_rdata (w_rdata)
    );

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_rsp.was_member  <= w_hit_any;
            r_rsp.bucket_full <= w_full;
        end
    end

    assign o_out_rsp = r_rsp;

endmodule

/* rtl/hsb_ctrl.sv */
// Controller: sequences the clear sweep, modulo stages, row read and write-back.
module hsb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output hsb_pkg::t_cmd o_cmd,
    input  hsb_pkg::t_sts i_sts
);

    import hsb_pkg::*;

    localparam int STW = 3;
    localparam logic [STW-1:0] S_CLEAR = 3'd0;
    localparam logic [STW-1:0] S_IDLE  = 3'd1;
    localparam logic [STW-1:0] S_MUL   = 3'd2;
    localparam logic [STW-1:0] S_REM   = 3'd3;
    localparam logic [STW-1:0] S_READ  = 3'd4;
    localparam logic [STW-1:0] S_UPD   = 3'd5;

    logic [STW-1:0] r_state;
    logic [STW-1:0] n_state;
    logic           r_out_valid;
    logic           n_out_valid;
    logic           w_accept;
    logic           w_out_free;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Drive datapath commands
    always_comb begin
        o_cmd.clear  = (r_state == S_CLEAR);
        o_cmd.load   = w_accept;
        o_cmd.mul    = (r_state == S_MUL);
        o_cmd.rem    = (r_state == S_REM);
        o_cmd.read   = (r_state == S_READ);
        o_cmd.update = (r_state == S_UPD) && w_out_free;
    end

    // Advance the sequence; hold in update until the result register frees
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_REM;
            S_REM:  n_state = S_READ;
            S_READ: n_state = S_UPD;
            S_UPD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Set valid on a new result, drop it once taken
    always_comb begin
        if (o_cmd.update) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/hash_set_bucketed.sv */
// Top level of the bucketed hash set: controller plus datapath.
//
// A set of keys held as NUM_BUCKETS rows of SLOTS_PER_BUCKET slots in one RAM
// row per bucket; a key lives in bucket key mod NUM_BUCKETS. Each request
// (insert, delete, test) returns one result: was_member tells whether the key
// was stored beforehand, and bucket_full flags an insert dropped because its
// bucket had no free slot. Between acceptance of one request and the next,
// it passes two multiply stages for the modulo by a constant, the RAM's
// registered row read, and compare and write-back. A finished result waits
// in an output register, so the next request is taken while it is still
// stalled, and only a second finished result waits on it. After reset the
// block clears the store one row per cycle and stalls requests meanwhile.
module hash_set_bucketed #(
    parameter int NUM_BUCKETS      = hsb_pkg::NUM_BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = hsb_pkg::SLOTS_PER_BUCKET_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  hsb_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output hsb_pkg::t_rsp o_out_rsp
);

    import hsb_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    hsb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    hsb_datapath #(
        .NUM_BUCKETS      (NUM_BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_in_req  (i_in_req),
        .o_sts     (w_sts),
        .o_out_rsp (o_out_rsp)
    );

endmodule

/* rtl/hsb_checker.sv */
// Port-level checks for the bucketed hash set, bound to the top level.
module hsb_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input hsb_pkg::t_req i_in_req,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input hsb_pkg::t_rsp o_out_rsp
);

    // A request is processed in stages: stall right after accepting
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted in back-to-back cycles");

    // A dropped insert never reports the key as present
    a_full_not_member: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_rsp.was_member && o_out_rsp.bucket_full))
        else $error("bucket_full reported together with was_member");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_rsp)))
        else $error("stalled result changed or dropped");

endmodule

bind hash_set_bucketed hsb_checker u_chk (.*);

/* dv/tb_hash_set_bucketed.sv */
// Testbench for the bucketed hash set: random insert/delete/test traffic checked against a model.
module tb_hash_set_bucketed;
    import hsb_pkg::*;

    localparam int NB      = NUM_BUCKETS_DEF;
    localparam int SL      = SLOTS_PER_BUCKET_DEF;
    localparam int N_SLOTS = NB * SL;
    localparam int N_RANDOM  = 1400;
    localparam int POOL_SIZE = 48;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    // Track the set contents and the results still owed by the block
    class hash_set_scoreboard;
        logic [KEY_W-1:0] stored_key [N_SLOTS];
        bit               slot_used  [N_SLOTS];
        t_rsp             owed_rsp   [$];
        int               errors;

        function new();
            for (int i = 0; i < N_SLOTS; i++) begin
                stored_key[i] = '0;
                slot_used[i]  = 1'b0;
            end
            errors = 0;
        endfunction

        // Apply one accepted request to the set and queue its result
        function void note_request(t_req req);
            int   base;
            int   hit;
            int   free_slot;
            t_rsp rsp;
            base      = int'(req.key % NB) * SL;
            hit       = -1;
            free_slot = -1;
            rsp       = '0;
            for (int s = 0; s < SL; s++) begin
                if (slot_used[base + s]) begin
                    if (hit < 0 && stored_key[base + s] == req.key)
                        hit = s;
                end else if (free_slot < 0) begin
                    free_slot = s;
                end
            end
            if (req.operation == OP_INSERT) begin
                if (hit < 0) begin
                    if (free_slot >= 0) begin
                        stored_key[base + free_slot] = req.key;
                        slot_used[base + free_slot]  = 1'b1;
                    end else begin
                        rsp.bucket_full = 1'b1;
                    end
                end
            end else if (req.operation == OP_DELETE) begin
                if (hit >= 0)
                    slot_used[base + hit] = 1'b0;
            end
            rsp.was_member = (hit >= 0);
            owed_rsp.push_back(rsp);
        endfunction

        // Compare one accepted result with the oldest one owed
        function void check_result(t_rsp got);
            t_rsp want;
            if (owed_rsp.size() == 0) begin
                $display("%0t: unexpected result was_member=%0b bucket_full=%0b",
                         $time, got.was_member, got.bucket_full);
                errors++;
                return;
            end
            want = owed_rsp.pop_front();
            if (got.was_member !== want.was_member) begin
                $display("%0t: was_member expected %0b actual %0b",
                         $time, want.was_member, got.was_member);
                errors++;
            end
            if (got.bucket_full !== want.bucket_full) begin
                $display("%0t: bucket_full expected %0b actual %0b",
                         $time, want.bucket_full, got.bucket_full);
                errors++;
            end
        endfunction

        function int outstanding();
            return owed_rsp.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_req i_in_req;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_rsp o_out_rsp;

    hash_set_scoreboard sb;
    bit                 calm;
    logic [KEY_W-1:0]   key_pool [POOL_SIZE];

    hash_set_bucketed #(
        .NUM_BUCKETS      (NB),
        .SLOTS_PER_BUCKET (SL)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    initial begin
        sb = new();
    end

    always #5 i_clk = ~i_clk;

    // Hold a request until the block takes it, then record it
    task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
        t_req req;
        req.operation = op;
        req.key       = key;
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_request(req);
    endtask

    // Now and then drop valid for a random idle stretch
    task automatic maybe_idle();
        if (!calm && $urandom_range(0, 99) < 9) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic send_random();
        int               pick;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            op = OP_INSERT;
        else if (pick < 70)
            op = OP_DELETE;
        else if (pick < 95)
            op = OP_TEST;
        else
            op = OP_UNUSED;
        // Mostly reuse pooled keys so buckets fill and hits occur
        if ($urandom_range(0, 99) < 85)
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            key = KEY_W'($urandom());
        send_request(op, key);
        maybe_idle();
    endtask

    // Accept and check results; stall at random outside the calm stretch
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_rsp);
        i_out_stall <= !calm && ($urandom_range(0, 99) < 9);
    end

    // Stimulus
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_req    = '0;
        calm        = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (i < POOL_SIZE / 2)
                key_pool[i] = KEY_W'($urandom_range(0, 60));
            else
                key_pool[i] = KEY_W'($urandom());
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: hits, misses, a full bucket, slot reuse, extreme keys
        send_request(OP_TEST,   31'd5);
        send_request(OP_INSERT, 31'd5);
        send_request(OP_INSERT, 31'd5);
        send_request(OP_TEST,   31'd5);
        send_request(OP_DELETE, 31'd5);
        send_request(OP_DELETE, 31'd5);
        send_request(OP_INSERT, 31'd0);
        send_request(OP_INSERT, 31'd10);
        send_request(OP_INSERT, 31'd20);
        send_request(OP_INSERT, 31'd30);
        send_request(OP_INSERT, 31'd40);
        send_request(OP_TEST,   31'd40);
        send_request(OP_DELETE, 31'd20);
        send_request(OP_INSERT, 31'd40);
        send_request(OP_TEST,   31'd20);
        send_request(OP_TEST,   31'd40);
        send_request(OP_INSERT, KEY_MAX);
        send_request(OP_UNUSED, KEY_MAX);
        send_request(OP_UNUSED, 31'd17);
        send_request(OP_DELETE, KEY_MAX);
        send_request(OP_TEST,   KEY_MAX);
        send_request(OP_INSERT, 31'h7FFF_FFF0);
        send_request(OP_DELETE, 31'd0);
        send_request(OP_INSERT, 31'h7FFF_FFF0);
        maybe_idle();

        // Random traffic with one stretch free of idling on both sides
        for (int n = 0; n < N_RANDOM; n++) begin
            calm = (n >= 600 && n < 850);
            send_random();
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        // Drain, then wait on for stray results
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Abort a hung run
    initial begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

endmodule
